// ===== rtl/prf_pkg.sv =====
package prf_pkg;

	localparam int SLOTS         = 8;
	localparam int MAX_PKT_BYTES = 64;

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int BIDX_W = (MAX_PKT_BYTES > 1) ? $clog2(MAX_PKT_BYTES) : 1;
	localparam int ADDR_W = SLOT_W + BIDX_W;
	localparam int RAM_DEPTH = SLOTS << BIDX_W;

	localparam int CMD_W    = 2;
	localparam int BYTE_W   = 8;
	localparam int LEN_W    = 7;
	localparam int STATUS_W = 3;
	localparam int OCC_W    = 3;

	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 24;

	localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(64);

	localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_GET   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	localparam logic [STATUS_W-1:0] ST_STORED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BYTE    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_LONG    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_SMALL   = 3'd5;
	localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd6;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [BYTE_W-1:0]   out_byte;
		logic                out_last;
		logic [LEN_W-1:0]    pkt_length;
		logic [OCC_W-1:0]    occupancy;
	} result_t;

	// one result headed for the output queue; byte_sel takes out_byte from the RAM
	typedef struct packed {
		logic    push;
		logic    byte_sel;
		result_t res;
	} resp_t;

	function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
		return (s == SLOT_W'(SLOTS - 1)) ? '0 : s + SLOT_W'(1);
	endfunction

	function automatic logic [OCC_W-1:0] occ_f(input logic [SLOT_W-1:0] w,
			input logic [SLOT_W-1:0] r);
		logic [SLOT_W:0] h;
		if (w >= r) begin
			h = {1'b0, w} - {1'b0, r};
		end else begin
			h = (SLOT_W+1)'(SLOTS) - ({1'b0, r} - {1'b0, w});
		end
		return OCC_W'(h);
	endfunction

endpackage

// ===== rtl/prf_ram.sv =====
module prf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/prf_out_queue.sv =====
module prf_out_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  prf_pkg::resp_t    resp_s1,
	input  logic [7:0]        ram_rdata,
	output logic              room,
	output logic              out_valid,
	input  logic              out_ready,
	output prf_pkg::result_t  out_res
);
	import prf_pkg::*;

	result_t head_q, tail_q, push_res;
	logic    v0_q, v1_q;
	logic    pop;
	logic [1:0] fill_next;

	always_comb begin
		push_res = resp_s1.res;
		if (resp_s1.byte_sel) begin
			push_res.out_byte = ram_rdata;
		end
	end

	assign pop       = v0_q & out_ready;
	// entries held after this edge; a read issued now lands in the next cycle
	assign fill_next = 2'(v0_q) + 2'(v1_q) + 2'(resp_s1.push) - 2'(pop);
	assign room      = (fill_next < 2'd2);
	assign out_valid = v0_q;
	assign out_res   = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
			v1_q <= 1'b0;
		end else begin
			priority if (pop && resp_s1.push) begin
				if (v1_q) begin
					head_q <= tail_q;
					tail_q <= push_res;
				end else begin
					head_q <= push_res;
				end
			end else if (pop) begin
				if (v1_q) begin
					head_q <= tail_q;
					v1_q   <= 1'b0;
				end else begin
					v0_q <= 1'b0;
				end
			end else if (resp_s1.push) begin
				if (!v0_q) begin
					head_q <= push_res;
					v0_q   <= 1'b1;
				end else begin
					tail_q <= push_res;
					v1_q   <= 1'b1;
				end
			end else begin
				// no transfer on either side: hold
			end
		end
	end

endmodule

// ===== rtl/prf_ctrl.sv =====
module prf_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [prf_pkg::CMD_W-1:0]     cmd,
	input  logic [prf_pkg::BYTE_W-1:0]    data_byte,
	input  logic                          last,
	input  logic [prf_pkg::LEN_W-1:0]     recv_capacity,
	input  logic                          cfg_valid,
	input  logic [prf_pkg::LEN_W-1:0]     cfg_data,
	input  logic                          room,
	output logic                          ram_we,
	output logic [prf_pkg::ADDR_W-1:0]    ram_waddr,
	output logic [prf_pkg::BYTE_W-1:0]    ram_wdata,
	output logic                          ram_re,
	output logic [prf_pkg::ADDR_W-1:0]    ram_raddr,
	output prf_pkg::resp_t                resp_s1
);
	import prf_pkg::*;

	typedef enum logic {S_IDLE, S_STREAM} state_t;

	localparam logic [1:0] DROP_NONE = 2'd0;
	localparam logic [1:0] DROP_FULL = 2'd1;
	localparam logic [1:0] DROP_LONG = 2'd2;

	state_t state_q, state_d;
	logic [SLOT_W-1:0] wr_q, wr_d, rd_q, rd_d;
	logic [LEN_W-1:0]  cnt_q, cnt_d, cnt_v;
	logic [1:0]        drop_q, drop_d, drop_v;
	logic [LEN_W-1:0]  maxlen_q, limit;
	logic [LEN_W-1:0]  len_q [SLOTS];
	logic              len_we;
	logic [SLOT_W-1:0] len_wsel;
	logic [LEN_W-1:0]  len_wval;
	logic [SLOT_W-1:0] str_slot_q, str_slot_d;
	logic [LEN_W-1:0]  str_idx_q, str_idx_d, str_len_q, str_len_d;
	logic [OCC_W-1:0]  str_occ_q, str_occ_d;
	logic              str_last;
	logic [LEN_W-1:0]  head_len;
	resp_t             resp_d;

	assign in_ready = (state_q == S_IDLE) && room;
	assign limit    = (maxlen_q < LEN_W'(MAX_PKT_BYTES)) ? maxlen_q : LEN_W'(MAX_PKT_BYTES);
	assign head_len = len_q[rd_q];
	assign str_last = (str_idx_q + LEN_W'(1)) == str_len_q;

	always_comb begin
		state_d    = state_q;
		wr_d       = wr_q;
		rd_d       = rd_q;
		cnt_d      = cnt_q;
		drop_d     = drop_q;
		cnt_v      = cnt_q;
		drop_v     = drop_q;
		str_slot_d = str_slot_q;
		str_idx_d  = str_idx_q;
		str_len_d  = str_len_q;
		str_occ_d  = str_occ_q;
		resp_d     = '0;
		len_we     = 1'b0;
		len_wsel   = wr_q;
		len_wval   = '0;
		ram_we     = 1'b0;
		ram_waddr  = {wr_q, cnt_q[BIDX_W-1:0]};
		ram_wdata  = data_byte;
		ram_re     = 1'b0;
		ram_raddr  = {str_slot_q, str_idx_q[BIDX_W-1:0]};

		if (state_q == S_STREAM) begin
			if (room) begin
				ram_re                  = 1'b1;
				resp_d.push             = 1'b1;
				resp_d.byte_sel         = 1'b1;
				resp_d.res.status       = ST_BYTE;
				resp_d.res.out_last     = str_last;
				resp_d.res.pkt_length   = str_len_q;
				resp_d.res.occupancy    = str_occ_q;
				str_idx_d               = str_idx_q + LEN_W'(1);
				if (str_last) begin
					state_d = S_IDLE;
				end
			end
		end else if (in_valid && room) begin
			unique case (cmd)
				CMD_PUT: begin
					if (cnt_q == '0 && drop_q == DROP_NONE && slot_next(wr_q) == rd_q) begin
						drop_v = DROP_FULL;
					end
					if (drop_v == DROP_NONE) begin
						if (cnt_q >= limit) begin
							drop_v = DROP_LONG;
						end else begin
							ram_we = 1'b1;
							cnt_v  = cnt_q + LEN_W'(1);
						end
					end
					if (last) begin
						resp_d.push         = 1'b1;
						resp_d.res.out_last = 1'b1;
						cnt_d               = '0;
						drop_d              = DROP_NONE;
						if (drop_v != DROP_NONE) begin
							resp_d.res.status    = (drop_v == DROP_FULL) ? ST_FULL : ST_LONG;
							resp_d.res.occupancy = occ_f(wr_q, rd_q);
						end else begin
							len_we                = 1'b1;
							len_wval              = cnt_v;
							wr_d                  = slot_next(wr_q);
							resp_d.res.status     = ST_STORED;
							resp_d.res.pkt_length = cnt_v;
							resp_d.res.occupancy  = occ_f(slot_next(wr_q), rd_q);
						end
					end else begin
						cnt_d  = cnt_v;
						drop_d = drop_v;
					end
				end
				CMD_GET: begin
					if (wr_q == rd_q) begin
						resp_d.push          = 1'b1;
						resp_d.res.out_last  = 1'b1;
						resp_d.res.status    = ST_EMPTY;
						resp_d.res.occupancy = occ_f(wr_q, rd_q);
					end else if (recv_capacity < head_len) begin
						resp_d.push          = 1'b1;
						resp_d.res.out_last  = 1'b1;
						resp_d.res.status    = ST_SMALL;
						resp_d.res.occupancy = occ_f(wr_q, rd_q);
					end else begin
						len_we     = 1'b1;
						len_wsel   = rd_q;
						rd_d       = slot_next(rd_q);
						state_d    = S_STREAM;
						str_slot_d = rd_q;
						str_idx_d  = '0;
						str_len_d  = head_len;
						str_occ_d  = occ_f(wr_q, slot_next(rd_q));
					end
				end
				CMD_CLEAR: begin
					wr_d                 = '0;
					rd_d                 = '0;
					cnt_d                = '0;
					drop_d               = DROP_NONE;
					resp_d.push          = 1'b1;
					resp_d.res.out_last  = 1'b1;
					resp_d.res.status    = ST_CLEARED;
					resp_d.res.occupancy = '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wr_q        <= '0;
			rd_q        <= '0;
			cnt_q       <= '0;
			drop_q      <= DROP_NONE;
			maxlen_q    <= MAX_LEN_RESET;
			str_slot_q  <= '0;
			str_idx_q   <= '0;
			str_len_q   <= '0;
			str_occ_q   <= '0;
			resp_s1     <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				len_q[i] <= '0;
			end
		end else begin
			state_q    <= state_d;
			wr_q       <= wr_d;
			rd_q       <= rd_d;
			cnt_q      <= cnt_d;
			drop_q     <= drop_d;
			str_slot_q <= str_slot_d;
			str_idx_q  <= str_idx_d;
			str_len_q  <= str_len_d;
			str_occ_q  <= str_occ_d;
			resp_s1    <= resp_d;
			if (cfg_valid) begin
				maxlen_q <= cfg_data;
			end
			if (len_we) begin
				len_q[len_wsel] <= len_wval;
			end
		end
	end

endmodule

// ===== rtl/packet_ring_fifo.sv =====
// Packet ring FIFO: a put streams one packet byte per transfer (tuser = command, tlast on
// the final byte); only the final byte gives a result. Clear, an empty or too-small get,
// and drops give one status result. An accepted get streams the oldest packet out of the
// 512 x 8 packet RAM at one byte per cycle while the master side takes them; the RAM read
// port feeds a two-entry output queue, so the slave side stays held until the packet's
// last byte is read, through any stall on the master side. No new command is taken while
// a get is streaming. The packet RAM has no reset and no clearing pass; only committed
// bytes are ever read. The ring holds at most SLOTS-1 packets.
module packet_ring_fifo (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [7:0] data_byte, [14:8] recv_capacity, [15] zero
	input  logic [prf_pkg::S_TDATA_W-1:0]   s_tdata,
	// [1:0] cmd
	input  logic [prf_pkg::CMD_W-1:0]       s_tuser,
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [7:0] out_byte, [14:8] pkt_length, [17:15] occupancy, [23:18] zero
	output logic [prf_pkg::M_TDATA_W-1:0]   m_tdata,
	// [2:0] status
	output logic [prf_pkg::STATUS_W-1:0]    m_tuser,
	output logic                            m_tlast,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [prf_pkg::LEN_W-1:0]       cfg_data
);
	import prf_pkg::*;

	logic              room;
	logic              ram_we, ram_re;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [BYTE_W-1:0] ram_wdata, ram_rdata;
	resp_t             resp_s1;
	result_t           out_res;

	assign cfg_ready = 1'b1;

	prf_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.cmd           (s_tuser),
		.data_byte     (s_tdata[7:0]),
		.last          (s_tlast),
		.recv_capacity (s_tdata[14:8]),
		.cfg_valid     (cfg_valid),
		.cfg_data      (cfg_data),
		.room          (room),
		.ram_we        (ram_we),
		.ram_waddr     (ram_waddr),
		.ram_wdata     (ram_wdata),
		.ram_re        (ram_re),
		.ram_raddr     (ram_raddr),
		.resp_s1       (resp_s1)
	);

	prf_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (RAM_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	prf_out_queue u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.resp_s1   (resp_s1),
		.ram_rdata (ram_rdata),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {6'd0, out_res.occupancy, out_res.pkt_length, out_res.out_byte};
	assign m_tuser = out_res.status;
	assign m_tlast = out_res.out_last;

endmodule

// ===== verif/tb_packet_ring_fifo.sv =====
module tb_packet_ring_fifo;
	import prf_pkg::*;

	localparam int HALF_PERIOD = 2;
	localparam int RESET_CYCLES = 7;
	localparam int STALL_LIMIT = 4000;
	localparam int LONG_HOLD = 400;
	localparam int MAX_REPORTS = 10;
	localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [BYTE_W-1:0] data;
		logic              last;
		logic [LEN_W-1:0]  cap;
	} pkt_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [CMD_W-1:0] s_tuser = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0] m_tuser;
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [LEN_W-1:0] cfg_data = '0;

	packet_ring_fifo u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// commands waiting for the driver, results waiting for the DUT
	pkt_cmd_t cmd_q[$];
	result_t  result_q[$];

	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int cfg_req = 0;
	int cfg_seen = 0;
	logic [LEN_W-1:0] cfg_val = '0;
	int mismatches = 0;
	int quiet_cycles = 0;

	// shadow state of the ring
	logic [BYTE_W-1:0] ring_store [SLOTS*MAX_PKT_BYTES];
	int ring_len [SLOTS];
	int wr_slot = 0;
	int rd_slot = 0;
	int fill_cnt = 0;
	logic drop_pending = 1'b0;
	logic [STATUS_W-1:0] drop_code = ST_FULL;
	int len_limit = 64;

	pkt_cmd_t drv_cmd;
	result_t got_res;
	result_t want_res;

	initial begin
		for (int i = 0; i < SLOTS; i++) ring_len[i] = 0;
	end

	function automatic int bump(input int s);
		return (s == SLOTS - 1) ? 0 : s + 1;
	endfunction

	function automatic result_t status_only(input logic [STATUS_W-1:0] st, input int len);
		result_t r;
		r = '0;
		r.status = st;
		r.out_last = 1'b1;
		r.pkt_length = LEN_W'(len);
		r.occupancy = OCC_W'((wr_slot - rd_slot + SLOTS) % SLOTS);
		return r;
	endfunction

	task automatic predict_ring(input pkt_cmd_t it);
		int lim;
		int n;
		int base;
		result_t r;
		if (it.cmd == CMD_PUT) begin
			lim = (len_limit < MAX_PKT_BYTES) ? len_limit : MAX_PKT_BYTES;
			// full is judged only at the first byte
			if (fill_cnt == 0 && !drop_pending && bump(wr_slot) == rd_slot) begin
				drop_pending = 1'b1;
				drop_code = ST_FULL;
			end
			if (!drop_pending) begin
				if (fill_cnt >= lim) begin
					drop_pending = 1'b1;
					drop_code = ST_LONG;
				end else begin
					ring_store[wr_slot*MAX_PKT_BYTES + fill_cnt] = it.data;
					fill_cnt++;
				end
			end
			if (it.last) begin
				if (drop_pending) begin
					drop_pending = 1'b0;
					fill_cnt = 0;
					result_q.push_back(status_only(drop_code, 0));
				end else begin
					n = fill_cnt;
					ring_len[wr_slot] = n;
					wr_slot = bump(wr_slot);
					fill_cnt = 0;
					result_q.push_back(status_only(ST_STORED, n));
				end
			end
		end else if (it.cmd == CMD_GET) begin
			if (wr_slot == rd_slot) begin
				result_q.push_back(status_only(ST_EMPTY, 0));
			end else begin
				n = ring_len[rd_slot];
				if (n > MAX_PKT_BYTES) n = MAX_PKT_BYTES;
				if (int'(it.cap) < n) begin
					result_q.push_back(status_only(ST_SMALL, 0));
				end else begin
					base = rd_slot * MAX_PKT_BYTES;
					ring_len[rd_slot] = 0;
					rd_slot = bump(rd_slot);
					for (int i = 0; i < n; i++) begin
						r = status_only(ST_BYTE, n);
						r.out_byte = ring_store[base + i];
						r.out_last = (i == n - 1);
						result_q.push_back(r);
					end
				end
			end
		end else if (it.cmd == CMD_CLEAR) begin
			wr_slot = 0;
			rd_slot = 0;
			fill_cnt = 0;
			drop_pending = 1'b0;
			result_q.push_back(status_only(ST_CLEARED, 0));
		end
	endtask

	// driver: next command once the current one is taken, unless a random idle gap is drawn
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (cmd_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				drv_cmd = cmd_q.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= drv_cmd.cmd;
				s_tdata <= {1'b0, drv_cmd.cap, drv_cmd.data};
				s_tlast <= drv_cmd.last;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver backpressure, with an occasional long hold
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= LONG_HOLD;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			cfg_valid <= 1'b0;
		end else if (cfg_valid) begin
			if (cfg_ready) begin
				cfg_valid <= 1'b0;
				len_limit = int'(cfg_data);
			end
		end else if (cfg_seen != cfg_req) begin
			cfg_seen <= cfg_req;
			cfg_valid <= 1'b1;
			cfg_data <= cfg_val;
		end
	end

	// monitor: check output transfers, then predict from input transfers
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_res.status = m_tuser;
			got_res.out_byte = m_tdata[7:0];
			got_res.out_last = m_tlast;
			got_res.pkt_length = m_tdata[14:8];
			got_res.occupancy = m_tdata[17:15];
			if (result_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result st=%0d byte=%02h last=%0b len=%0d occ=%0d",
						got_res.status, got_res.out_byte, got_res.out_last,
						got_res.pkt_length, got_res.occupancy);
			end else begin
				want_res = result_q.pop_front();
				if (got_res !== want_res) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("mismatch exp st=%0d byte=%02h last=%0b len=%0d occ=%0d",
							want_res.status, want_res.out_byte, want_res.out_last,
							want_res.pkt_length, want_res.occupancy);
						$display("         got st=%0d byte=%02h last=%0b len=%0d occ=%0d",
							got_res.status, got_res.out_byte, got_res.out_last,
							got_res.pkt_length, got_res.occupancy);
					end
				end
			end
		end
		if (arst_n && s_tvalid && s_tready)
			predict_ring('{cmd: s_tuser, data: s_tdata[7:0], last: s_tlast,
				cap: s_tdata[14:8]});
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb_packet_ring_fifo NOT OK");
				$finish;
			end
		end
	end

	task automatic send(input logic [CMD_W-1:0] c, input logic [BYTE_W-1:0] d,
			input logic l, input logic [LEN_W-1:0] cap);
		cmd_q.push_back('{cmd: c, data: d, last: l, cap: cap});
	endtask

	function automatic logic [LEN_W-1:0] pick_cap();
		int p;
		p = $urandom_range(99);
		if (p < 70) return LEN_W'($urandom_range(64, 127));
		if (p < 90) return LEN_W'($urandom_range(0, 8));
		return LEN_W'($urandom_range(0, 127));
	endfunction

	task automatic send_get(input logic [LEN_W-1:0] cap);
		send(CMD_GET, BYTE_W'($urandom), 1'($urandom), cap);
	endtask

	task automatic send_packet(input int len);
		for (int k = 0; k < len; k++)
			send(CMD_PUT, BYTE_W'($urandom), k == len - 1, LEN_W'($urandom));
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (cmd_q.size() != 0 || s_tvalid || result_q.size() != 0);
		// non-final put bytes give no result; let the pipeline settle
		repeat (8) @(negedge clk);
	endtask

	task automatic set_max_len(input logic [LEN_W-1:0] v);
		cfg_val = v;
		cfg_req++;
		do @(negedge clk);
		while (cfg_seen != cfg_req || cfg_valid);
	endtask

	// mostly well-formed packets with gets; some gets and clears land mid-packet
	task automatic gen_traffic(input int budget, input int big_pct);
		int sent;
		int len;
		int p;
		sent = 0;
		while (sent < budget) begin
			p = $urandom_range(99);
			if (p < 55) begin
				if ($urandom_range(99) < big_pct)
					len = $urandom_range(MAX_PKT_BYTES - 4, MAX_PKT_BYTES + 6);
				else
					len = $urandom_range(1, 6);
				for (int k = 0; k < len; k++) begin
					send(CMD_PUT, BYTE_W'($urandom), k == len - 1, LEN_W'($urandom));
					sent++;
					if ($urandom_range(99) < 6) begin
						send_get(pick_cap());
						sent++;
					end else if ($urandom_range(999) < 8) begin
						send(CMD_CLEAR, BYTE_W'($urandom), 1'($urandom), LEN_W'($urandom));
						sent++;
					end
				end
			end else if (p < 90) begin
				send_get(pick_cap());
				sent++;
			end else if (p < 94) begin
				send(CMD_CLEAR, BYTE_W'($urandom), 1'($urandom), LEN_W'($urandom));
				sent++;
			end else begin
				send(CMD_NONE, BYTE_W'($urandom), 1'($urandom), LEN_W'($urandom));
			end
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty, two stores, small capacity, a streamed get, ignored code, clear
		send(CMD_GET, 8'h00, 1'b1, 7'd0);
		send(CMD_PUT, 8'h00, 1'b1, 7'h00);
		send(CMD_PUT, 8'hFF, 1'b1, 7'h7F);
		send(CMD_GET, 8'hFF, 1'b0, 7'd0);
		send(CMD_GET, 8'h00, 1'b1, 7'd127);
		send(CMD_NONE, 8'hAA, 1'b1, 7'h55);
		send(CMD_CLEAR, 8'h55, 1'b0, 7'h2A);
		// fill the ring, then a packet that starts full keeps its drop across a get
		for (int i = 0; i < SLOTS - 1; i++) send(CMD_PUT, BYTE_W'(8'h10 + i), 1'b1, 7'd0);
		send(CMD_PUT, 8'h5A, 1'b0, 7'd0);
		send(CMD_GET, 8'h00, 1'b0, 7'd127);
		send(CMD_PUT, 8'hA5, 1'b1, 7'd0);
		send(CMD_CLEAR, 8'h00, 1'b1, 7'd0);
		wait_drained();

		set_max_len(7'd2);
		send_packet(3);
		send_packet(2);
		send_get(7'd2);
		wait_drained();

		set_max_len(7'd0);
		send_packet(1);
		wait_drained();

		// limit above the slot size falls back to the slot size
		set_max_len(7'd127);
		send_packet(MAX_PKT_BYTES);
		send_get(7'(MAX_PKT_BYTES - 1));
		send_get(7'(MAX_PKT_BYTES));
		send_packet(MAX_PKT_BYTES + 1);
		wait_drained();

		set_max_len(7'd64);
		gen_traffic(40, 3);
		wait_drained();
		gen_traffic(15, 0);
		wait_drained();

		src_idle_pct = 68;
		gen_traffic(35, 0);
		wait_drained();

		src_idle_pct = 0;
		sink_stall_pct = 68;
		set_max_len(7'd1);
		gen_traffic(25, 0);
		wait_drained();

		src_idle_pct = 32;
		sink_stall_pct = 32;
		set_max_len(LEN_W'($urandom_range(3, 40)));
		gen_traffic(45, 5);
		wait_drained();

		// long receiver hold while the sender keeps pushing
		src_idle_pct = 0;
		sink_stall_pct = 0;
		set_max_len(7'd64);
		hold_req++;
		for (int i = 0; i < 6; i++) send_packet($urandom_range(10, 20));
		for (int i = 0; i < 6; i++) send_get(7'd127);
		gen_traffic(15, 0);
		wait_drained();

		src_idle_pct = 32;
		sink_stall_pct = 32;
		gen_traffic(25, 2);
		wait_drained();

		repeat (20) @(negedge clk);
		if (mismatches == 0 && result_q.size() == 0)
			$display("tb_packet_ring_fifo OK");
		else
			$display("tb_packet_ring_fifo NOT OK");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/prf_pkg.sv
rtl/prf_ram.sv
rtl/prf_out_queue.sv
rtl/prf_ctrl.sv
rtl/packet_ring_fifo.sv
verif/tb_packet_ring_fifo.sv
